// ===== src/lrc_pkg.sv =====
package lrc_pkg;

  // operator codes
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_OTHER = 3'd5
  } op_t;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam int VALUE_W = 32;
  localparam int EXT_W   = 64;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      divide_by_zero;
  } out_req_t;

  // sequencer -> arithmetic unit
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctl_t;

  // arithmetic unit -> sequencer
  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_sts_t;

  function automatic op_t decode_op(input logic [7:0] c);
    op_t op;
    case (c)
      CHAR_PLUS:  op = OP_ADD;
      CHAR_MINUS: op = OP_SUB;
      CHAR_STAR:  op = OP_MUL;
      CHAR_SLASH: op = OP_DIV;
      default:    op = OP_OTHER;
    endcase
    return op;
  endfunction

endpackage

// ===== src/lrc_alu.sv =====
// Shared arithmetic unit: add/sub/pass, shift-add multiply and
// restoring divide, one bit per cycle.
module lrc_alu #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lrc_pkg::alu_ctl_t ctl,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      result,
  output lrc_pkg::alu_sts_t sts
);

  localparam int CW = $clog2(W);

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_FIX
  } ustate_t;

  ustate_t       state_r, state_nxt;
  logic [W-1:0]  acc_r, acc_nxt;     // product / partial remainder
  logic [W-1:0]  sh_r, sh_nxt;       // multiplier / dividend-quotient
  logic [W-1:0]  opnd_r, opnd_nxt;   // multiplicand / divisor
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          done_r, done_nxt;
  logic          dz_r, dz_nxt;
  logic [W:0]    trial;
  logic [W-1:0]  abs_a, abs_b;

  assign trial = {acc_r, sh_r[W-1]} - {1'b0, opnd_r};
  assign abs_a = a[W-1] ? (~a + 1'b1) : a;
  assign abs_b = b[W-1] ? (~b + 1'b1) : b;

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    opnd_nxt  = opnd_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    dz_nxt    = dz_r;
    done_nxt  = 1'b0;
    case (state_r)
      U_IDLE: begin
        if (ctl.start) begin
          dz_nxt = 1'b0;
          case (ctl.op)
            lrc_pkg::OP_NONE: begin
              res_nxt  = b;
              done_nxt = 1'b1;
            end
            lrc_pkg::OP_ADD: begin
              res_nxt  = a + b;
              done_nxt = 1'b1;
            end
            lrc_pkg::OP_SUB: begin
              res_nxt  = a - b;
              done_nxt = 1'b1;
            end
            lrc_pkg::OP_MUL: begin
              acc_nxt   = '0;
              opnd_nxt  = a;
              sh_nxt    = b;
              cnt_nxt   = CW'(W - 1);
              state_nxt = U_MUL;
            end
            lrc_pkg::OP_DIV: begin
              if (b == '0) begin
                res_nxt  = '0;
                dz_nxt   = 1'b1;
                done_nxt = 1'b1;
              end else begin
                acc_nxt   = '0;
                sh_nxt    = abs_a;
                opnd_nxt  = abs_b;
                neg_nxt   = a[W-1] ^ b[W-1];
                cnt_nxt   = CW'(W - 1);
                state_nxt = U_DIV;
              end
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      U_MUL: begin
        if (sh_r[0]) begin
          acc_nxt = acc_r + opnd_r;
        end
        opnd_nxt = {opnd_r[W-2:0], 1'b0};
        sh_nxt   = {1'b0, sh_r[W-1:1]};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_nxt   = acc_nxt;
          done_nxt  = 1'b1;
          state_nxt = U_IDLE;
        end
      end
      U_DIV: begin
        if (!trial[W]) begin
          acc_nxt = trial[W-1:0];
        end else begin
          acc_nxt = {acc_r[W-2:0], sh_r[W-1]};
        end
        sh_nxt  = {sh_r[W-2:0], ~trial[W]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = U_FIX;
        end
      end
      U_FIX: begin
        res_nxt   = neg_r ? (~sh_r + 1'b1) : sh_r;
        done_nxt  = 1'b1;
        state_nxt = U_IDLE;
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      acc_r   <= acc_nxt;
      sh_r    <= sh_nxt;
      opnd_r  <= opnd_nxt;
      cnt_r   <= cnt_nxt;
      neg_r   <= neg_nxt;
      res_r   <= res_nxt;
      dz_r    <= dz_nxt;
    end
  end

  assign result       = res_r;
  assign sts.done     = done_r;
  assign sts.div_zero = dz_r;

endmodule

// ===== src/left_to_right_calculator.sv =====
// Left-to-right calculator: takes an expression one ASCII character per
// request and returns one result request after the character flagged
// end_of_expression. No precedence; arithmetic wraps at DATA_WIDTH bits and
// the value is presented on 32 bits. A digit that is not the last character
// is taken without leaving the idle state. An operator character applies
// the pending operator on the arithmetic unit: +, -, a pass or an unknown
// operator finish without a bit loop, while * and / run the bit loop (a zero
// divisor skips it). This work is done by the single shared arithmetic unit,
// whose multiply and divide retire one bit per cycle. The last character adds
// one more apply of the pending operator on the same unit and then a load of
// the output register, and that load waits while an earlier result is still
// stalled there. in_stall is high while an item is in work. A finished result
// sits in the output register, so the next expression may start while it waits to be taken.
module left_to_right_calculator #(
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lrc_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output lrc_pkg::out_req_t out_req
);

  localparam int W = DATA_WIDTH;

  typedef enum logic [1:0] {
    T_IDLE,   // taking characters
    T_OP,     // applying pending operator for an operator character
    T_FIN,    // final apply at end of expression
    T_OUT     // waiting for the output register
  } tstate_t;

  tstate_t           state_r, state_nxt;
  logic [W-1:0]      rr_r, rr_nxt;        // running result
  logic [W-1:0]      cur_r, cur_nxt;      // number being read
  lrc_pkg::op_t      pend_r, pend_nxt;    // pending operator
  lrc_pkg::op_t      new_op_r, new_op_nxt;
  logic              last_r, last_nxt;
  logic              err_r, err_nxt;
  logic              start_r, start_nxt;
  lrc_pkg::out_req_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic                      accept;
  logic                      is_digit;
  logic [W-1:0]              digit_val;
  logic [lrc_pkg::EXT_W-1:0] rr_ext;

  lrc_pkg::alu_ctl_t alu_ctl;
  lrc_pkg::alu_sts_t alu_sts;
  logic [W-1:0]      alu_res;

  assign in_stall  = (state_r != T_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_digit  = in_req.symbol inside {[lrc_pkg::CHAR_0:lrc_pkg::CHAR_9]};
  assign digit_val = W'(in_req.symbol - lrc_pkg::CHAR_0);
  // value is the low 32 bits of the width-wrapped result
  assign rr_ext    = lrc_pkg::EXT_W'(rr_r);

  // operands always come from registers; start is a registered pulse
  assign alu_ctl.start = start_r;
  assign alu_ctl.op    = pend_r;

  lrc_alu #(
    .W(W)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .a      (rr_r),
    .b      (cur_r),
    .result (alu_res),
    .sts    (alu_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    rr_nxt        = rr_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    new_op_nxt    = new_op_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    start_nxt     = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          last_nxt = in_req.end_of_expression;
          if (is_digit) begin
            // cur * 10 + digit
            cur_nxt = {cur_r[W-4:0], 3'b000} + {cur_r[W-2:0], 1'b0} + digit_val;
            if (in_req.end_of_expression) begin
              start_nxt = 1'b1;
              state_nxt = T_FIN;
            end
          end else begin
            new_op_nxt = lrc_pkg::decode_op(in_req.symbol);
            start_nxt  = 1'b1;
            state_nxt  = T_OP;
          end
        end
      end
      T_OP: begin
        if (alu_sts.done) begin
          rr_nxt   = alu_res;
          err_nxt  = err_r | alu_sts.div_zero;
          pend_nxt = new_op_r;
          cur_nxt  = '0;
          if (last_r) begin
            start_nxt = 1'b1;
            state_nxt = T_FIN;
          end else begin
            state_nxt = T_IDLE;
          end
        end
      end
      T_FIN: begin
        if (alu_sts.done) begin
          rr_nxt    = alu_res;
          err_nxt   = err_r | alu_sts.div_zero;
          state_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.value          = signed'(rr_ext[lrc_pkg::VALUE_W-1:0]);
          out_nxt.divide_by_zero = err_r;
          out_valid_nxt          = 1'b1;
          // back to the start-of-expression state
          rr_nxt    = '0;
          cur_nxt   = '0;
          pend_nxt  = lrc_pkg::OP_NONE;
          err_nxt   = 1'b0;
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      rr_r        <= '0;
      cur_r       <= '0;
      pend_r      <= lrc_pkg::OP_NONE;
      err_r       <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rr_r        <= rr_nxt;
      cur_r       <= cur_nxt;
      pend_r      <= pend_nxt;
      new_op_r    <= new_op_nxt;
      last_r      <= last_nxt;
      err_r       <= err_nxt;
      start_r     <= start_nxt;
      out_r       <= out_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

endmodule

// ===== src/lrc_checker.sv =====
module lrc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input lrc_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_stall,
  input lrc_pkg::out_req_t out_req
);

  logic in_acc;
  logic in_digit;

  assign in_acc   = in_valid && !in_stall;
  assign in_digit = (in_req.symbol >= lrc_pkg::CHAR_0) && (in_req.symbol <= lrc_pkg::CHAR_9);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("result changed while stalled");

  // a digit in mid-expression leaves the input free in the next cycle
  a_digit_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_digit && !in_req.end_of_expression |=> !in_stall)
    else $error("busy after a plain digit");

  // an operator always occupies the arithmetic unit
  a_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_digit |=> in_stall)
    else $error("not busy after an operator");

  // a new result only comes out of a busy period
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in progress");

endmodule

bind left_to_right_calculator lrc_checker u_lrc_checker (.*);
